// ===== hdl/rgb_to_hsv_converter_defines.svh =====
// Assertion macros used by the checker file.
`ifndef RGB_TO_HSV_CONVERTER_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_DEFINES_SVH

// Asserts that an implication holds at every clock edge outside reset.
`define RHC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Asserts that a consequent holds in the cycle after an antecedent.
`define RHC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/rhc_pkg.sv =====
`timescale 1ns / 1ps
package rhc_pkg;

    localparam int unsigned CH_W   = 8;
    localparam int unsigned HUE_W  = 9;
    localparam int unsigned PCT_W  = 7;
    localparam int unsigned QUO_W  = 15;  // 100*255 needs 15 bits

    localparam logic [1:0] SEC_RED   = 2'd0;
    localparam logic [1:0] SEC_GREEN = 2'd1;
    localparam logic [1:0] SEC_BLUE  = 2'd2;
    localparam logic [1:0] SEC_GREY  = 2'd3;

    // One classified pixel as the front part hands it to the back part.
    typedef struct packed {
        logic [1:0]       sector;
        logic             neg;          // sector difference negative
        logic [QUO_W-1:0] hue_num;      // magnitude of hue numerator
        logic [QUO_W-1:0] sat_num;      // 100*delta
        logic [CH_W-1:0]  delta;
        logic [CH_W-1:0]  mx;
        logic [PCT_W-1:0] brightness;
    } rhc_item_t;

    // Result triple.
    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [PCT_W-1:0] saturation;
        logic [PCT_W-1:0] brightness;
    } rhc_result_t;

endpackage

// ===== hdl/rhc_front.sv =====
`timescale 1ns / 1ps
// Finds max, min and the sector, forms numerators and the brightness.
module rhc_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            red,
    input  logic [7:0]            green,
    input  logic [7:0]            blue,
    output logic                  out_valid,
    input  logic                  out_ready,
    output rhc_pkg::rhc_item_t    out_item
);
    localparam int unsigned QW = rhc_pkg::QUO_W;

    logic                 valid_reg;
    rhc_pkg::rhc_item_t   item_reg;
    rhc_pkg::rhc_item_t   item_next;
    logic [7:0]           mx;
    logic [7:0]           mn;
    logic [7:0]           dlt;
    logic [8:0]           df;
    logic                 neg;
    logic [7:0]           mag;
    logic [14:0]          v100;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        mx  = (red > green) ? red : green;
        mx  = (mx > blue) ? mx : blue;
        mn  = (red < green) ? red : green;
        mn  = (mn < blue) ? mn : blue;
        dlt = mx - mn;
        item_next.mx    = mx;
        item_next.delta = dlt;
        item_next.sat_num = QW'(dlt) * QW'(100);
        if (dlt == 8'd0) begin
            item_next.sector = rhc_pkg::SEC_GREY;
            df = 9'd0;
        end else if (mx == red) begin
            item_next.sector = rhc_pkg::SEC_RED;
            df = {1'b0, green} - {1'b0, blue};
        end else if (mx == green) begin
            item_next.sector = rhc_pkg::SEC_GREEN;
            df = {1'b0, blue} - {1'b0, red};
        end else begin
            item_next.sector = rhc_pkg::SEC_BLUE;
            df = {1'b0, red} - {1'b0, green};
        end
        neg = df[8];
        mag = neg ? 8'(-df) : df[7:0];
        item_next.neg = neg;
        item_next.hue_num = QW'(mag) * QW'(60);
        v100 = 15'(mx) * 15'd100;
        // Division by 255: x/255 = (x + (x>>8) + 1) >> 8 for x up to 100*255.
        item_next.brightness =
            7'((16'(v100) + 16'(v100 >> 8) + 16'd1) >> 8);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
endmodule

// ===== hdl/rhc_queue.sv =====
`timescale 1ns / 1ps
// Two-entry queue between the front and back parts.
module rhc_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  rhc_pkg::rhc_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output rhc_pkg::rhc_item_t out_item
);
    rhc_pkg::rhc_item_t mem_reg [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         count_reg;
    logic               push;
    logic               pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end
endmodule

// ===== hdl/rhc_back.sv =====
`timescale 1ns / 1ps
// Pipelined restoring dividers for hue and saturation, then the sector fix-up.
module rhc_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rhc_pkg::rhc_item_t   in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rhc_pkg::rhc_result_t out_result
);
    localparam int unsigned NST = rhc_pkg::QUO_W;

    typedef struct packed {
        logic [1:0]                 sector;
        logic                       neg;
        logic [13:0]                hrem;   // remainder and quotient shifted together
        logic [rhc_pkg::QUO_W-1:0]  hquo;
        logic [13:0]                srem;
        logic [rhc_pkg::QUO_W-1:0]  squo;
        logic [7:0]                 delta;
        logic [7:0]                 mx;
        logic [6:0]                 brightness;
    } stage_t;

    stage_t     st_reg [NST+1];
    logic       vld_reg [NST+1];
    stage_t     st_next [NST+1];
    logic       adv;
    logic [9:0] h;
    logic [9:0] hq;

    // The whole pipe moves when the output end is free.
    assign adv      = !vld_reg[NST] || out_ready;
    assign in_ready = adv;

    always_comb begin
        st_next[0].sector     = in_item.sector;
        st_next[0].neg        = in_item.neg;
        st_next[0].hrem       = 14'd0;
        st_next[0].hquo       = in_item.hue_num;
        st_next[0].srem       = 14'd0;
        st_next[0].squo       = in_item.sat_num;
        st_next[0].delta      = in_item.delta;
        st_next[0].mx         = in_item.mx;
        st_next[0].brightness = in_item.brightness;
        for (int i = 1; i <= NST; i++) begin
            logic [14:0] hr;
            logic [14:0] sr;
            st_next[i] = st_reg[i-1];
            hr = {st_reg[i-1].hrem, st_reg[i-1].hquo[rhc_pkg::QUO_W-1]};
            sr = {st_reg[i-1].srem, st_reg[i-1].squo[rhc_pkg::QUO_W-1]};
            st_next[i].hquo = {st_reg[i-1].hquo[rhc_pkg::QUO_W-2:0], 1'b0};
            st_next[i].squo = {st_reg[i-1].squo[rhc_pkg::QUO_W-2:0], 1'b0};
            if (hr >= 15'(st_reg[i-1].delta) && st_reg[i-1].delta != 8'd0) begin
                hr = hr - 15'(st_reg[i-1].delta);
                st_next[i].hquo[0] = 1'b1;
            end
            if (sr >= 15'(st_reg[i-1].mx) && st_reg[i-1].mx != 8'd0) begin
                sr = sr - 15'(st_reg[i-1].mx);
                st_next[i].squo[0] = 1'b1;
            end
            st_next[i].hrem = hr[13:0];
            st_next[i].srem = sr[13:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= NST; i++) vld_reg[i] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i <= NST; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st_reg[0] <= st_next[0];
            for (int i = 1; i <= NST; i++) st_reg[i] <= st_next[i];
        end
    end

    always_comb begin
        hq = st_reg[NST].hquo[9:0];
        case (st_reg[NST].sector)
            rhc_pkg::SEC_RED:   h = st_reg[NST].neg ? 10'd360 - hq : hq;
            rhc_pkg::SEC_GREEN: h = st_reg[NST].neg ? 10'd120 - hq : 10'd120 + hq;
            rhc_pkg::SEC_BLUE:  h = st_reg[NST].neg ? 10'd240 - hq : 10'd240 + hq;
            default:            h = 10'd0;
        endcase
        // Green and blue use floor; a negative inexact part rounds one lower.
        if (st_reg[NST].neg && st_reg[NST].hrem != 14'd0 &&
            st_reg[NST].sector != rhc_pkg::SEC_RED) begin
            h = h - 10'd1;
        end
        if (h >= 10'd360) h = h - 10'd360;
        out_result.hue        = h[8:0];
        out_result.saturation = st_reg[NST].squo[6:0];
        out_result.brightness = st_reg[NST].brightness;
    end

    assign out_valid = vld_reg[NST];
endmodule

// ===== hdl/rgb_to_hsv_converter.sv =====
`timescale 1ns / 1ps
// Channel  Direction  tdata fields (low bit first)
// s_axis   in         red[7:0], green[15:8], blue[23:16]
// m_axis   out        hue[8:0], saturation[15:9], brightness[22:16], zero pad to 24
//
// One pixel is accepted every cycle while no m_axis stall has backed up the pipe.
// A pixel passes through the front register, the queue slot, the divider input stage
// and the 15 stages of the hue and saturation restoring dividers.
// aresetn is synchronous and empties every stage.
// A stall on m_axis holds the divider pipe; the two-entry queue keeps the front
// accepting until it fills.
module rgb_to_hsv_converter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red, green, blue
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // hue, saturation, brightness
);
    rhc_pkg::rhc_item_t   f_item;
    rhc_pkg::rhc_item_t   q_item;
    rhc_pkg::rhc_result_t res;
    logic                 f_valid;
    logic                 f_ready;
    logic                 q_valid;
    logic                 q_ready;

    rhc_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .red(s_axis_tdata[7:0]), .green(s_axis_tdata[15:8]),
        .blue(s_axis_tdata[23:16]),
        .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
    );

    rhc_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
        .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
    );

    rhc_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_result(res)
    );

    assign m_axis_tdata = {1'b0, res.brightness, res.saturation, res.hue};
endmodule

// ===== hdl/rgb_to_hsv_converter_checker.sv =====
`timescale 1ns / 1ps
`include "rgb_to_hsv_converter_defines.svh"
// Watches the ports of the converter.
module rgb_to_hsv_converter_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [23:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);
    `RHC_ASSERT_IMP(a_hue_range, aclk, aresetn, m_axis_tvalid, m_axis_tdata[8:0] < 9'd360)
    `RHC_ASSERT_IMP(a_sat_range, aclk, aresetn, m_axis_tvalid, m_axis_tdata[15:9] <= 7'd100)
    `RHC_ASSERT_IMP(a_val_range, aclk, aresetn, m_axis_tvalid, m_axis_tdata[22:16] <= 7'd100)
    `RHC_ASSERT_NEXT(a_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
endmodule

bind rgb_to_hsv_converter rgb_to_hsv_converter_checker u_checker (.*);

// ===== test/tb_rgb_to_hsv_converter.sv =====
`timescale 1ns / 1ps
module tb_rgb_to_hsv_converter;

    // One expected HSV triple for each accepted pixel.
    class hsv_scoreboard;
        logic [8:0] hue_q[$];
        logic [6:0] sat_q[$];
        logic [6:0] val_q[$];
        int errors = 0;
        int checked = 0;

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            int mx, mn, delta, h, diff;
            mx = (r > g) ? r : g;
            mx = (mx > b) ? mx : b;
            mn = (r < g) ? r : g;
            mn = (mn < b) ? mn : b;
            delta = mx - mn;
            h = 0;
            if (delta != 0) begin
                if (mx == r) begin
                    diff = int'(g) - int'(b);
                    if (diff >= 0) begin
                        h = (60 * diff) / delta;
                    end else begin
                        h = -((60 * -diff) / delta);
                        if (h < 0) h += 360;
                    end
                end else if (mx == g) begin
                    h = (60 * (int'(b) - int'(r)) + 120 * delta) / delta;
                end else begin
                    h = (60 * (int'(r) - int'(g)) + 240 * delta) / delta;
                end
                if (h >= 360) h -= 360;
            end
            hue_q.push_back(h[8:0]);
            sat_q.push_back(mx == 0 ? 7'd0 : 7'((100 * delta) / mx));
            val_q.push_back(7'((100 * mx) / 255));
        endfunction

        task check_result(logic [23:0] d);
            logic [8:0] eh;
            logic [6:0] es, ev;
            if (hue_q.size() == 0) begin
                report($sformatf("unexpected result %h", d));
                return;
            end
            eh = hue_q.pop_front();
            es = sat_q.pop_front();
            ev = val_q.pop_front();
            checked++;
            if (d[8:0] != eh) report($sformatf("hue %0d, expected %0d", d[8:0], eh));
            if (d[15:9] != es) report($sformatf("saturation %0d, expected %0d", d[15:9], es));
            if (d[22:16] != ev)
                report($sformatf("brightness %0d, expected %0d", d[22:16], ev));
            if (d[23] != 1'b0) report("pad bit set");
        endtask

        function int pending();
            return hue_q.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;

    hsv_scoreboard sb;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_off = 0;
    int cycles = 0;
    int pixels_sent = 0;

    localparam int CYCLE_LIMIT = 200000;

    rgb_to_hsv_converter u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL rgb_to_hsv_converter");
            $finish;
        end
    end

    // Offers one pixel, idling at random first, and returns once it is accepted.
    // The valid line is left high; drain(), or an idle gap in the next call, takes it down.
    task send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {b, g, r};
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_pixel(r, g, b);
        pixels_sent++;
    endtask

    task send_random(int n);
        logic [7:0] r, g, b;
        for (int i = 0; i < n; i++) begin
            r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
            case ($urandom_range(7))
                0: begin g = r; b = r; end             // grey
                1: g = r;                              // red and green tie
                2: b = g;
                3: begin r = 8'd255; b = 8'd0; end
                default: ;
            endcase
            send_pixel(r, g, b);
        end
    endtask

    task drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    initial begin
        sb = new();
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_pixel(8'd0, 8'd0, 8'd0);       // black
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128); // grey
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);   // red and green equal to max
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd1);     // red sector, negative difference
        send_pixel(8'd255, 8'd1, 8'd0);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd1, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd1);
        send_pixel(8'd200, 8'd100, 8'd199);
        send_pixel(8'd10, 8'd200, 8'd11);
        send_pixel(8'd254, 8'd253, 8'd255);
        send_pixel(8'd170, 8'd85, 8'd85);
        drain();

        send_random(130);
        idle_pct = 57;
        send_random(110);
        idle_pct = 0; stall_pct = 57;
        send_random(110);
        idle_pct = 6; stall_pct = 6;
        send_random(60);
        drain();

        // Hold the receiver off long enough for the pipe and queue to back up.
        idle_pct = 0; stall_pct = 0;
        hold_off = 80;
        send_random(60);
        drain();
        repeat (30) @(posedge aclk);

        $display("Sent %0d pixels through idle and stall phases, including a long back-pressure",
                 pixels_sent);
        $display("stretch; %0d results compared.", sb.checked);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS rgb_to_hsv_converter");
        end else begin
            $display("FAIL rgb_to_hsv_converter");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/rhc_pkg.sv
hdl/rhc_front.sv
hdl/rhc_queue.sv
hdl/rhc_back.sv
hdl/rgb_to_hsv_converter.sv
hdl/rgb_to_hsv_converter_checker.sv
test/tb_rgb_to_hsv_converter.sv
